// File: src/mmix_pkg.sv
`timescale 1ns / 1ps

package mmix_pkg;

  // sizing
  localparam int MOTORS_MAX  = 8;
  localparam int RESULTS_MAX = 8;
  localparam int ADDR_W      = (MOTORS_MAX > 1) ? $clog2(MOTORS_MAX) : 1;
  localparam int CNT_MAX     = (MOTORS_MAX < RESULTS_MAX) ? MOTORS_MAX : RESULTS_MAX;

  // field widths
  localparam int CMD_W   = 16;
  localparam int LEVEL_W = 15;
  localparam int IDX_W   = 3;
  localparam int CNT_W   = 4;
  localparam int CFG_W   = 2;

  // arithmetic widths
  localparam int Q_SHIFT  = 14;
  localparam int PROD_W   = 2 * CMD_W;
  localparam int PART_W   = 18;
  localparam int RP_W     = PART_W + 1;
  localparam int THR_W    = 20;
  localparam int BASE_W   = 21;
  localparam int HEAD_W   = 22;
  localparam int M_W      = 22;
  localparam int SCALE_W  = 15;
  localparam int QUOT_W   = 14;
  localparam int DVS_W    = 17;
  localparam int YPROD_W  = PART_W + SCALE_W + 1;
  localparam int COEF_W   = 3 * CMD_W;
  localparam int SCR_W    = RP_W + PART_W;
  localparam int DCNT_W   = $clog2(QUOT_W + 1);

  localparam logic [SCALE_W-1:0] ONE_Q14 = SCALE_W'(16384);

  // configuration register indexes
  localparam logic [CFG_W-1:0] CFG_MOTOR_COUNT = 2'd0;
  localparam logic [CFG_W-1:0] CFG_IDLE_LEVEL  = 2'd1;
  localparam logic [CFG_W-1:0] CFG_MAX_LEVEL   = 2'd2;

  // configuration reset values
  localparam logic [CNT_W-1:0]   RST_MOTOR_COUNT = 4'd4;
  localparam logic [LEVEL_W-1:0] RST_IDLE_LEVEL  = 15'd0;
  localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL   = 15'd16384;

  // item function codes
  localparam logic FUNC_MIX  = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P1_RD,
    S_P1_MUL,
    S_P1_ACC,
    S_THR,
    S_HD_RD,
    S_HD_BASE,
    S_HD_DEC,
    S_DIV,
    S_MX_RD,
    S_MX_MUL,
    S_MX_SUM,
    S_MX_CLAMP,
    S_ZERO,
    S_OUT
  } mmix_state_t;

  typedef struct packed {
    logic             start;
    logic [DVS_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: src/multirotor_motor_mixer_top.sv
`timescale 1ns / 1ps

// Motor mixer with yaw desaturation.
// Input channel (in_valid/in_ready): a mix transaction carries roll, pitch,
// yaw and thrust demands in signed Q2.14; a load transaction (in_func set)
// writes one coefficient row and gives no result.
// Result channel (out_valid/out_ready): one transaction per motor in use,
// in index order, last_motor set on the final one. Disarmed (thrust of zero
// or less) gives zero drive for every motor.
// Configuration: cfg_we writes register cfg_index (motor count, idle level,
// max level) at once; write only while the block is idle.
// One item at a time; in_ready is high only while idle. In an armed mix
// each motor whose yaw needs a scale division waits for the 14-step
// serial divider, and every result waits for out_ready: a stalled
// receiver holds the block and the waiting result unchanged.
// Reset clears the coefficient table (through row valid bits) and puts the
// registers at four motors, idle 0 and max 1.0.

module multirotor_motor_mixer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  logic signed [mmix_pkg::CMD_W-1:0] in_roll_cmd,
  input  logic signed [mmix_pkg::CMD_W-1:0] in_pitch_cmd,
  input  logic signed [mmix_pkg::CMD_W-1:0] in_yaw_cmd,
  input  logic signed [mmix_pkg::CMD_W-1:0] in_thrust_cmd,
  input  logic [mmix_pkg::IDX_W-1:0]       in_row_index,
  input  logic signed [mmix_pkg::CMD_W-1:0] in_coef_roll,
  input  logic signed [mmix_pkg::CMD_W-1:0] in_coef_pitch,
  input  logic signed [mmix_pkg::CMD_W-1:0] in_coef_yaw,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mmix_pkg::IDX_W-1:0]       out_motor_index,
  output logic [mmix_pkg::LEVEL_W-1:0]     out_motor_drive,
  output logic                             out_last_motor,
  // configuration
  input  logic                             cfg_we,
  input  logic [mmix_pkg::CFG_W-1:0]       cfg_index,
  input  logic [mmix_pkg::LEVEL_W-1:0]     cfg_wdata
);

  import mmix_pkg::*;

  mmix_state_t state_r, state_nxt;

  // configuration registers
  logic [CNT_W-1:0]   motor_count_r;
  logic [LEVEL_W-1:0] idle_level_r;
  logic [LEVEL_W-1:0] max_level_r;

  // control
  logic [IDX_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  disarm_r, disarm_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [MOTORS_MAX-1:0] row_valid_r, row_valid_nxt;

  // datapath
  logic signed [CMD_W-1:0]   roll_r, roll_nxt;
  logic signed [CMD_W-1:0]   pitch_r, pitch_nxt;
  logic signed [CMD_W-1:0]   yaw_r, yaw_nxt;
  logic signed [THR_W-1:0]   thrust_r, thrust_nxt;
  logic                      coef_ok_r, coef_ok_nxt;
  logic signed [PROD_W-1:0]  prod_roll_r, prod_roll_nxt;
  logic signed [PROD_W-1:0]  prod_pitch_r, prod_pitch_nxt;
  logic signed [PROD_W-1:0]  prod_yaw_r, prod_yaw_nxt;
  logic signed [RP_W-1:0]    rp_min_r, rp_min_nxt;
  logic signed [RP_W-1:0]    rp_max_r, rp_max_nxt;
  logic [SCALE_W-1:0]        scale_r, scale_nxt;
  logic signed [HEAD_W-1:0]  head_r, head_nxt;
  logic [DVS_W-1:0]          ay_r, ay_nxt;
  logic                      yz_r, yz_nxt;
  logic signed [YPROD_W-1:0] yprod_r, yprod_nxt;
  logic signed [RP_W-1:0]    rp_hold_r, rp_hold_nxt;
  logic signed [M_W-1:0]     m_r, m_nxt;
  logic [IDX_W-1:0]          out_index_r, out_index_nxt;
  logic [LEVEL_W-1:0]        out_drive_r, out_drive_nxt;
  logic                      out_last_r, out_last_nxt;

  // memories
  logic                      coef_we;
  logic [ADDR_W-1:0]         coef_waddr;
  logic [COEF_W-1:0]         coef_wdata;
  logic [COEF_W-1:0]         coef_rdata;
  logic                      scr_we;
  logic [SCR_W-1:0]          scr_wdata;
  logic [SCR_W-1:0]          scr_rdata;
  logic [ADDR_W-1:0]         rd_addr;

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // combinational helpers
  logic                      in_acc;
  logic                      row_ok;
  logic                      last_w;
  logic [CNT_W-1:0]          count_lim;
  logic signed [CMD_W-1:0]   c_roll, c_pitch, c_yaw;
  logic signed [PART_W-1:0]  part_roll, part_pitch, part_yaw;
  logic signed [RP_W-1:0]    rp_w;
  logic signed [THR_W-1:0]   hi_lim, lo_lim, thr_hi;
  logic signed [RP_W-1:0]    s_rp;
  logic signed [PART_W-1:0]  s_y;
  logic signed [PART_W:0]    s_y_ext, s_y_neg;
  logic signed [BASE_W-1:0]  base_w;
  logic signed [HEAD_W-1:0]  max_h, idle_h, ay_h;
  logic                      shrink;
  logic signed [M_W-1:0]     idle_m, max_m, m_lo;

  assign in_acc    = in_valid && in_ready;
  assign row_ok    = (32'(in_row_index) < MOTORS_MAX);
  assign last_w    = ({1'b0, n_r} == (count_r - CNT_W'(1)));
  assign count_lim = (motor_count_r > CNT_W'(CNT_MAX)) ? CNT_W'(CNT_MAX) : motor_count_r;
  assign rd_addr   = ADDR_W'(n_r);

  // coefficient table, rows not yet written read as zero
  assign coef_we    = in_acc && (in_func == FUNC_LOAD) && row_ok;
  assign coef_waddr = ADDR_W'(in_row_index);
  assign coef_wdata = {in_coef_roll, in_coef_pitch, in_coef_yaw};

  mmix_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MOTORS_MAX)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (rd_addr),
    .rdata (coef_rdata)
  );

  // per-motor roll/pitch part and yaw part kept between passes
  assign scr_we    = (state_r == S_P1_ACC);
  assign scr_wdata = {rp_w, part_yaw};

  mmix_ram #(
    .WIDTH (SCR_W),
    .DEPTH (MOTORS_MAX)
  ) u_scr_ram (
    .clk   (clk),
    .we    (scr_we),
    .waddr (rd_addr),
    .wdata (scr_wdata),
    .raddr (rd_addr),
    .rdata (scr_rdata)
  );

  mmix_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // arithmetic shared by the passes
  always_comb begin
    c_roll     = coef_ok_r ? $signed(coef_rdata[3*CMD_W-1:2*CMD_W]) : '0;
    c_pitch    = coef_ok_r ? $signed(coef_rdata[2*CMD_W-1:CMD_W]) : '0;
    c_yaw      = coef_ok_r ? $signed(coef_rdata[CMD_W-1:0]) : '0;
    part_roll  = PART_W'(prod_roll_r >>> Q_SHIFT);
    part_pitch = PART_W'(prod_pitch_r >>> Q_SHIFT);
    part_yaw   = PART_W'(prod_yaw_r >>> Q_SHIFT);
    rp_w       = RP_W'(part_roll) + RP_W'(part_pitch);
    hi_lim     = THR_W'($signed({1'b0, max_level_r})) - THR_W'(rp_max_r);
    lo_lim     = THR_W'($signed({1'b0, idle_level_r})) - THR_W'(rp_min_r);
    thr_hi     = (thrust_r > hi_lim) ? hi_lim : thrust_r;
    s_rp       = $signed(scr_rdata[SCR_W-1:PART_W]);
    s_y        = $signed(scr_rdata[PART_W-1:0]);
    s_y_ext    = (PART_W+1)'(s_y);
    s_y_neg    = -s_y_ext;
    base_w     = BASE_W'(thrust_r) + BASE_W'(s_rp);
    max_h      = HEAD_W'($signed({1'b0, max_level_r}));
    idle_h     = HEAD_W'($signed({1'b0, idle_level_r}));
    ay_h       = HEAD_W'($signed({1'b0, ay_r}));
    shrink     = !yz_r && (head_r < ay_h);
    idle_m     = M_W'($signed({1'b0, idle_level_r}));
    max_m      = M_W'($signed({1'b0, max_level_r}));
    m_lo       = (m_r < idle_m) ? idle_m : m_r;
  end

  // sequencer: three motor passes, results in the third; zeros if disarmed
  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    count_nxt      = count_r;
    disarm_nxt     = disarm_r;
    out_valid_nxt  = out_valid_r;
    row_valid_nxt  = row_valid_r;
    roll_nxt       = roll_r;
    pitch_nxt      = pitch_r;
    yaw_nxt        = yaw_r;
    thrust_nxt     = thrust_r;
    coef_ok_nxt    = row_valid_r[rd_addr];
    prod_roll_nxt  = prod_roll_r;
    prod_pitch_nxt = prod_pitch_r;
    prod_yaw_nxt   = prod_yaw_r;
    rp_min_nxt     = rp_min_r;
    rp_max_nxt     = rp_max_r;
    scale_nxt      = scale_r;
    head_nxt       = head_r;
    ay_nxt         = ay_r;
    yz_nxt         = yz_r;
    yprod_nxt      = yprod_r;
    rp_hold_nxt    = rp_hold_r;
    m_nxt          = m_r;
    out_index_nxt  = out_index_r;
    out_drive_nxt  = out_drive_r;
    out_last_nxt   = out_last_r;
    div_req        = '0;
    in_ready       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          roll_nxt   = in_roll_cmd;
          pitch_nxt  = in_pitch_cmd;
          yaw_nxt    = in_yaw_cmd;
          thrust_nxt = THR_W'(in_thrust_cmd);
          count_nxt  = count_lim;
          n_nxt      = '0;
          rp_min_nxt = '0;
          rp_max_nxt = '0;
          disarm_nxt = (in_thrust_cmd <= 0);
          if (in_func == FUNC_LOAD) begin
            if (row_ok) begin
              row_valid_nxt[coef_waddr] = 1'b1;
            end
          end else if (count_lim != '0) begin
            state_nxt = (in_thrust_cmd <= 0) ? S_ZERO : S_P1_RD;
          end
        end
      end

      // pass one: roll/pitch parts, their extremes
      S_P1_RD: begin
        state_nxt = S_P1_MUL;
      end
      S_P1_MUL: begin
        prod_roll_nxt  = c_roll * roll_r;
        prod_pitch_nxt = c_pitch * pitch_r;
        prod_yaw_nxt   = c_yaw * yaw_r;
        state_nxt      = S_P1_ACC;
      end
      S_P1_ACC: begin
        if (rp_w < rp_min_r) begin
          rp_min_nxt = rp_w;
        end
        if (rp_w > rp_max_r) begin
          rp_max_nxt = rp_w;
        end
        if (last_w) begin
          state_nxt = S_THR;
        end else begin
          n_nxt     = n_r + IDX_W'(1);
          state_nxt = S_P1_RD;
        end
      end

      // thrust limit, lower bound wins
      S_THR: begin
        thrust_nxt = (thr_hi < lo_lim) ? lo_lim : thr_hi;
        scale_nxt  = ONE_Q14;
        n_nxt      = '0;
        state_nxt  = S_HD_RD;
      end

      // pass two: yaw headroom and scale
      S_HD_RD: begin
        state_nxt = S_HD_BASE;
      end
      S_HD_BASE: begin
        yz_nxt = (s_y == '0);
        if (s_y > 0) begin
          head_nxt = max_h - HEAD_W'(base_w);
          ay_nxt   = DVS_W'(s_y_ext);
        end else begin
          head_nxt = HEAD_W'(base_w) - idle_h;
          ay_nxt   = DVS_W'(s_y_neg);
        end
        state_nxt = S_HD_DEC;
      end
      S_HD_DEC: begin
        if (shrink && (head_r > 0)) begin
          div_req.start    = 1'b1;
          div_req.dividend = head_r[DVS_W-1:0];
          div_req.divisor  = ay_r;
          state_nxt        = S_DIV;
        end else begin
          if (shrink) begin
            scale_nxt = '0;
          end
          if (last_w) begin
            n_nxt     = '0;
            state_nxt = S_MX_RD;
          end else begin
            n_nxt     = n_r + IDX_W'(1);
            state_nxt = S_HD_RD;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (SCALE_W'(div_rsp.quot) < scale_r) begin
            scale_nxt = SCALE_W'(div_rsp.quot);
          end
          if (last_w) begin
            n_nxt     = '0;
            state_nxt = S_MX_RD;
          end else begin
            n_nxt     = n_r + IDX_W'(1);
            state_nxt = S_HD_RD;
          end
        end
      end

      // pass three: drive values
      S_MX_RD: begin
        state_nxt = S_MX_MUL;
      end
      S_MX_MUL: begin
        yprod_nxt   = s_y * $signed({1'b0, scale_r});
        rp_hold_nxt = s_rp;
        state_nxt   = S_MX_SUM;
      end
      S_MX_SUM: begin
        m_nxt     = M_W'(thrust_r) + M_W'(rp_hold_r) + M_W'(yprod_r >>> Q_SHIFT);
        state_nxt = S_MX_CLAMP;
      end
      S_MX_CLAMP: begin
        out_index_nxt = n_r;
        out_drive_nxt = (m_lo > max_m) ? max_level_r : m_lo[LEVEL_W-1:0];
        out_last_nxt  = last_w;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end

      // disarmed
      S_ZERO: begin
        out_index_nxt = n_r;
        out_drive_nxt = '0;
        out_last_nxt  = last_w;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end

      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            n_nxt     = n_r + IDX_W'(1);
            state_nxt = disarm_r ? S_ZERO : S_MX_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      count_r     <= '0;
      disarm_r    <= 1'b0;
      out_valid_r <= 1'b0;
      row_valid_r <= '0;
      coef_ok_r   <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      count_r     <= count_nxt;
      disarm_r    <= disarm_nxt;
      out_valid_r <= out_valid_nxt;
      row_valid_r <= row_valid_nxt;
      coef_ok_r   <= coef_ok_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_count_r <= RST_MOTOR_COUNT;
      idle_level_r  <= RST_IDLE_LEVEL;
      max_level_r   <= RST_MAX_LEVEL;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MOTOR_COUNT) begin
        motor_count_r <= cfg_wdata[CNT_W-1:0];
      end
      if (cfg_index == CFG_IDLE_LEVEL) begin
        idle_level_r <= cfg_wdata;
      end
      if (cfg_index == CFG_MAX_LEVEL) begin
        max_level_r <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    roll_r       <= roll_nxt;
    pitch_r      <= pitch_nxt;
    yaw_r        <= yaw_nxt;
    thrust_r     <= thrust_nxt;
    prod_roll_r  <= prod_roll_nxt;
    prod_pitch_r <= prod_pitch_nxt;
    prod_yaw_r   <= prod_yaw_nxt;
    rp_min_r     <= rp_min_nxt;
    rp_max_r     <= rp_max_nxt;
    scale_r      <= scale_nxt;
    head_r       <= head_nxt;
    ay_r         <= ay_nxt;
    yz_r         <= yz_nxt;
    yprod_r      <= yprod_nxt;
    rp_hold_r    <= rp_hold_nxt;
    m_r          <= m_nxt;
    out_index_r  <= out_index_nxt;
    out_drive_r  <= out_drive_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_motor_index = out_index_r;
  assign out_motor_drive = out_drive_r;
  assign out_last_motor  = out_last_r;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_div_operands: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (div_req.dividend != '0) && (div_req.dividend < div_req.divisor))
    else $error("divider started outside its quotient range");

  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MX_MUL) |-> (scale_r <= ONE_Q14))
    else $error("yaw scale above one");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_motor) |=> in_ready)
    else $error("block not idle after the final result");

endmodule

// File: src/mmix_ram.sv
`timescale 1ns / 1ps

module mmix_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/mmix_div.sv
`timescale 1ns / 1ps

module mmix_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mmix_pkg::div_req_t req,
  output mmix_pkg::div_rsp_t rsp
);

  import mmix_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;

  // restoring division of dividend * 2^14 by divisor, dividend below divisor
  always_comb begin
    trial    = {rem_r, 1'b0};
    diff     = trial - {1'b0, dvs_r};
    fits     = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(QUOT_W);
      rem_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      quot_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quot_nxt = {quot_r[QUOT_W-2:0], fits};
      cnt_nxt  = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule
